### rtl/core/rqm_pkg.sv
// Shared types and codes for the ring queue with id mark.
// Used by rqm_cell and ring_queue_with_id_mark_core; no dependencies.
package rqm_pkg;

  localparam int ID_W  = 16;
  localparam int PAY_W = 64;

  // Operation codes carried on in_mode
  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_MARK = 2'd2,
    MODE_LIST = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_REPLY,
    S_MARK,
    S_LIST
  } state_t;

  // One stored queue entry
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    logic             done;
  } entry_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic            push;       // cell at the tail slot loads the write word
    logic            shift;      // every cell takes its upper neighbor (pop)
    logic            rotate;     // shift, the newest valid cell takes the front
    logic            tok_start;  // search token starts at cell 0
    logic            tok_step;   // search token moves one cell up
    logic            tok_clear;  // search token removed
    logic            mark_en;    // cell holding the token may set its done flag
    logic [ID_W-1:0] key;        // id searched on mark
  } cell_ctl_t;

endpackage

### rtl/core/rqm_cell.sv
// One slot of the queue chain: entry storage, neighbor shift and search token.
// Depends on rqm_pkg.
module rqm_cell #(
  parameter int DEPTH = 64,
  parameter int IDX   = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rqm_pkg::cell_ctl_t           ctl,
  input  logic [$clog2(DEPTH+1)-1:0]   cnt,
  input  rqm_pkg::entry_t              wr_ent,
  input  rqm_pkg::entry_t              nbr_ent,
  input  rqm_pkg::entry_t              front_ent,
  input  logic                         tok_in,
  output rqm_pkg::entry_t              ent_o,
  output logic                         tok_o,
  output logic                         hit_o,
  output logic                         end_o
);
  import rqm_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] POS     = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS_END = CNT_W'(IDX + 1);

  entry_t ent_r, ent_nxt;
  logic   tok_r, tok_nxt;
  logic   is_tail, is_end, match;

  assign is_tail = (cnt == POS);
  assign is_end  = (cnt == POS_END);
  assign match   = tok_r && (ent_r.id == ctl.key);

  // entry update: push, pop shift, list rotation or done mark
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.push && is_tail) begin
      ent_nxt = wr_ent;
    end else if (ctl.shift) begin
      ent_nxt = nbr_ent;
    end else if (ctl.rotate) begin
      ent_nxt = is_end ? front_ent : nbr_ent;
    end else if (ctl.mark_en && match) begin
      ent_nxt.done = 1'b1;
    end
  end

  // search token
  always_comb begin
    tok_nxt = tok_r;
    if (ctl.tok_clear) begin
      tok_nxt = 1'b0;
    end else if (ctl.tok_start) begin
      tok_nxt = (POS == '0);
    end else if (ctl.tok_step) begin
      tok_nxt = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign ent_o = ent_r;
  assign tok_o = tok_r;
  assign hit_o = match;
  assign end_o = tok_r && is_end;

endmodule

### rtl/core/ring_queue_with_id_mark_core.sv
// Ring queue with id mark: top level, sequencer and chain of entry cells.
// Depends on rqm_pkg and rqm_cell.
//
// Usage: one input word carries an operation (push, pop, mark, list) with an
// id, a 64-bit payload and a done flag. Each operation answers with result
// words on the out_ channel; the final one has out_last set.
// The queue is a chain of DEPTH cells, oldest entry in cell 0. Pop shifts the
// chain by one cell. Mark passes a search token up the chain one cell per
// cycle. List rotates the chain one cell per emitted word, so after a full
// list the order is back where it started.
// Sequence: push and pop go from idle to the reply state, which loads the
// result into the output register and returns to idle. Mark starts the token
// at cell 0 and moves it one cell a cycle until it reaches the first matching
// entry, oldest first, or the newest entry when none matches; mark on an empty
// queue goes straight to the reply state. List emits one result word per
// rotation step; list on an empty queue goes straight to the reply state.
// A new word is taken only when the previous operation has placed its last
// result in the output register; that result may still wait there.
// When the receiver stalls, the output register holds its word and the
// sequencer waits. Reset empties the queue; no clearing pass is needed.
module ring_queue_with_id_mark_core #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [rqm_pkg::ID_W-1:0]    in_item_id,
  input  logic [rqm_pkg::PAY_W-1:0]   in_payload,
  input  logic                        in_done_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [rqm_pkg::ID_W-1:0]    out_entry_id,
  output logic [rqm_pkg::PAY_W-1:0]   out_entry_payload,
  output logic                        out_entry_done,
  output logic                        out_last
);
  import rqm_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [ID_W-1:0]    key_r, key_nxt;
  status_t            status_r, status_nxt;

  cell_ctl_t          ctl;
  entry_t             wr_ent;
  entry_t             ent [DEPTH];
  logic [DEPTH-1:0]   tok_vec, hit_vec, end_vec;
  logic               any_hit, any_end;

  logic               out_valid_r;
  logic               out_load;
  status_t            out_status_d;
  entry_t             out_ent_d;
  logic               out_last_d;
  status_t            out_status_r;
  entry_t             out_ent_r;
  logic               out_last_r;
  logic               out_free;
  logic               in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign wr_ent.id      = in_item_id;
  assign wr_ent.payload = in_payload;
  assign wr_ent.done    = in_done_in;

  // chain of cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    entry_t nbr;
    logic   tin;
    if (k == DEPTH - 1) begin : g_top
      assign nbr = ent[k];
    end else begin : g_mid
      assign nbr = ent[k+1];
    end
    if (k == 0) begin : g_first
      assign tin = 1'b0;
    end else begin : g_rest
      assign tin = tok_vec[k-1];
    end
    rqm_cell #(.DEPTH(DEPTH), .IDX(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cnt       (cnt_r),
      .wr_ent    (wr_ent),
      .nbr_ent   (nbr),
      .front_ent (ent[0]),
      .tok_in    (tin),
      .ent_o     (ent[k]),
      .tok_o     (tok_vec[k]),
      .hit_o     (hit_vec[k]),
      .end_o     (end_vec[k])
    );
  end

  assign any_hit = |hit_vec;
  assign any_end = |end_vec;

  // sequencer: next state, chain control and output load
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    key_nxt      = key_r;
    status_nxt   = status_r;
    ctl          = '0;
    ctl.key      = key_r;
    out_load     = 1'b0;
    out_status_d = status_r;
    out_ent_d    = '0;
    out_last_d   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (mode_t'(in_mode))
            MODE_PUSH: begin
              state_nxt = S_REPLY;
              if (cnt_r == CNT_FULL) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt = ST_OK;
                ctl.push   = 1'b1;
                cnt_nxt    = cnt_r + CNT_ONE;
              end
            end
            MODE_POP: begin
              state_nxt = S_REPLY;
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                status_nxt = ST_OK;
                ctl.shift  = 1'b1;
                cnt_nxt    = cnt_r - CNT_ONE;
              end
            end
            MODE_MARK: begin
              key_nxt = in_item_id;
              if (cnt_r == '0) begin
                status_nxt = ST_NOTFOUND;
                state_nxt  = S_REPLY;
              end else begin
                ctl.tok_start = 1'b1;
                state_nxt     = S_MARK;
              end
            end
            MODE_LIST: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_REPLY;
              end else begin
                rem_nxt   = cnt_r;
                state_nxt = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MARK: begin
        ctl.mark_en = 1'b1;
        if (any_hit) begin
          ctl.tok_clear = 1'b1;
          status_nxt    = ST_OK;
          state_nxt     = S_REPLY;
        end else if (any_end) begin
          ctl.tok_clear = 1'b1;
          status_nxt    = ST_NOTFOUND;
          state_nxt     = S_REPLY;
        end else begin
          ctl.tok_step = 1'b1;
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_OK;
          out_ent_d    = ent[0];
          out_last_d   = (rem_r == CNT_ONE);
          ctl.rotate   = 1'b1;
          rem_nxt      = rem_r - CNT_ONE;
          if (rem_r == CNT_ONE) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rem_r    <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rem_r    <= rem_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_d;
      out_ent_r    <= out_ent_d;
      out_last_r   <= out_last_d;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_id      = out_ent_r.id;
  assign out_entry_payload = out_ent_r.payload;
  assign out_entry_done    = out_ent_r.done;
  assign out_last          = out_last_r;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above depth");

  a_tok_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one search token");

  a_tok_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MARK |-> $onehot(tok_vec))
    else $error("search without a token");

  a_list_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LIST |-> (rem_r != '0) && (rem_r <= cnt_r))
    else $error("list remainder out of range");

  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> cnt_r == $past(cnt_r) + CNT_ONE)
    else $error("push did not grow the count");

endmodule

### bench/testbench.sv
// Self-checking bench for ring_queue_with_id_mark_core: push, pop, mark and list.
// Needs rqm_pkg and the core RTL. A behavioral queue predicts each reply word,
// and every accepted result is checked field by field, oldest first.
module testbench;
  import rqm_pkg::*;

  localparam int QDEPTH      = 64;
  localparam int DRAIN_CYCLES = 2 * QDEPTH + 16;

  // One expected reply word
  typedef struct {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    logic             done;
    logic             last;
  } reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_mode = MODE_PUSH;
  logic [ID_W-1:0]  in_item_id = '0;
  logic [PAY_W-1:0] in_payload = '0;
  logic             in_done_in = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_status;
  logic [ID_W-1:0]  out_entry_id;
  logic [PAY_W-1:0] out_entry_payload;
  logic             out_entry_done;
  logic             out_last;

  // Behavioral copy of the queue
  logic [ID_W-1:0]  q_id   [QDEPTH];
  logic [PAY_W-1:0] q_pay  [QDEPTH];
  logic             q_done [QDEPTH];
  int               q_head = 0;
  int               q_tail = 0;
  int               q_count = 0;

  reply_t pending_replies[$];
  int     mismatch_count = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;

  ring_queue_with_id_mark_core #(.DEPTH(QDEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_item_id        (in_item_id),
    .in_payload        (in_payload),
    .in_done_in        (in_done_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_entry_id      (out_entry_id),
    .out_entry_payload (out_entry_payload),
    .out_entry_done    (out_entry_done),
    .out_last          (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                 input logic [PAY_W-1:0] want);
    $display("mismatch @%0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void add_reply(input status_t st, input logic [ID_W-1:0] id,
                                    input logic [PAY_W-1:0] pay, input logic done,
                                    input logic last);
    reply_t r;
    r.status  = st;
    r.id      = id;
    r.payload = pay;
    r.done    = done;
    r.last    = last;
    pending_replies.push_back(r);
  endfunction

  // Apply one accepted word to the queue copy and queue up its replies
  function automatic void predict_op(input mode_t mode, input logic [ID_W-1:0] id,
                                     input logic [PAY_W-1:0] pay, input logic done);
    int slot;
    bit hit;
    slot = q_head;
    hit = 1'b0;
    case (mode)
      MODE_PUSH: begin
        if (q_count >= QDEPTH) begin
          add_reply(ST_FULL, '0, '0, 1'b0, 1'b1);
        end else begin
          q_id[q_tail]   = id;
          q_pay[q_tail]  = pay;
          q_done[q_tail] = done;
          q_tail = (q_tail + 1) % QDEPTH;
          q_count++;
          add_reply(ST_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      MODE_POP: begin
        if (q_count == 0) begin
          add_reply(ST_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          q_head = (q_head + 1) % QDEPTH;
          q_count--;
          add_reply(ST_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      MODE_MARK: begin
        // only the oldest matching entry gets marked
        for (int n = 0; n < q_count && !hit; n++) begin
          if (q_id[slot] == id) begin
            q_done[slot] = 1'b1;
            hit = 1'b1;
          end
          slot = (slot + 1) % QDEPTH;
        end
        add_reply(hit ? ST_OK : ST_NOTFOUND, '0, '0, 1'b0, 1'b1);
      end
      default: begin
        if (q_count == 0) begin
          add_reply(ST_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          for (int n = 0; n < q_count; n++) begin
            add_reply(ST_OK, q_id[slot], q_pay[slot], q_done[slot], n + 1 == q_count);
            slot = (slot + 1) % QDEPTH;
          end
        end
      end
    endcase
  endfunction

  // Result checker and receiver stall generator
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected word, status", out_status, '0);
      end else begin
        want = pending_replies.pop_front();
        if (out_status != want.status)
          report_mismatch("status", out_status, want.status);
        if (out_entry_id != want.id)
          report_mismatch("entry_id", out_entry_id, want.id);
        if (out_entry_payload != want.payload)
          report_mismatch("entry_payload", out_entry_payload, want.payload);
        if (out_entry_done != want.done)
          report_mismatch("entry_done", out_entry_done, want.done);
        if (out_last != want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Send one word; fields hold until the block takes it
  task automatic send_word(input mode_t mode, input logic [ID_W-1:0] id,
                           input logic [PAY_W-1:0] pay, input logic done);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_item_id <= id;
    in_payload <= pay;
    in_done_in <= done;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_op(mode, id, pay, done);
  endtask

  task automatic set_pressure(input int idle_pct, input int stall_rate);
    send_idle_pct = idle_pct;
    stall_pct     = stall_rate;
  endtask

  // Id of a random live entry, or a random id when the queue is empty
  function automatic logic [ID_W-1:0] live_id();
    if (q_count == 0)
      return ID_W'($urandom);
    return q_id[(q_head + $urandom_range(q_count - 1)) % QDEPTH];
  endfunction

  // One random word; weights in percent for push, pop and mark, list takes the rest
  task automatic send_random(input int push_w, input int pop_w, input int mark_w);
    int r;
    logic [ID_W-1:0] id;
    r = $urandom_range(99);
    // small ids half the time so duplicates show up
    id = $urandom_range(1) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
    if (r < push_w)
      send_word(MODE_PUSH, id, {$urandom, $urandom}, 1'($urandom_range(1)));
    else if (r < push_w + pop_w)
      send_word(MODE_POP, ID_W'($urandom), {$urandom, $urandom}, 1'($urandom_range(1)));
    else if (r < push_w + pop_w + mark_w)
      send_word(MODE_MARK, $urandom_range(3) != 0 ? live_id() : id,
                {$urandom, $urandom}, 1'($urandom_range(1)));
    else
      send_word(MODE_LIST, ID_W'($urandom), {$urandom, $urandom}, 1'($urandom_range(1)));
  endtask

  // Pop, mark and list on an empty queue
  task automatic test_empty_queue();
    set_pressure(0, 0);
    send_word(MODE_POP, '0, '0, 1'b0);
    send_word(MODE_MARK, 16'h1234, '0, 1'b0);
    send_word(MODE_LIST, '1, '1, 1'b1);
  endtask

  // All-zero and all-one fields stored and listed back
  task automatic test_field_extremes();
    set_pressure(73, 0);
    send_word(MODE_PUSH, '0, '0, 1'b0);
    send_word(MODE_PUSH, '1, '1, 1'b1);
    send_word(MODE_LIST, '0, '0, 1'b0);
    send_word(MODE_POP, '0, '0, 1'b0);
    send_word(MODE_POP, '0, '0, 1'b0);
  endtask

  // Duplicate ids, re-marking a done entry, missing id
  task automatic test_mark_cases();
    set_pressure(0, 73);
    send_word(MODE_PUSH, 16'd5, 64'h1111_0000_0000_0001, 1'b0);
    send_word(MODE_PUSH, 16'd9, 64'h2222_0000_0000_0002, 1'b0);
    send_word(MODE_PUSH, 16'd5, 64'h3333_0000_0000_0003, 1'b0);
    send_word(MODE_PUSH, 16'd9, 64'h4444_0000_0000_0004, 1'b1);
    send_word(MODE_MARK, 16'd5, '0, 1'b0);
    send_word(MODE_LIST, '0, '0, 1'b0);
    send_word(MODE_MARK, 16'd5, '0, 1'b0);
    send_word(MODE_MARK, 16'd9, '0, 1'b0);
    send_word(MODE_MARK, 16'd9, '0, 1'b0);
    send_word(MODE_LIST, '0, '0, 1'b0);
    send_word(MODE_MARK, 16'hBEEF, '0, 1'b0);
    repeat (4) send_word(MODE_POP, '0, '0, 1'b0);
  endtask

  // Fill past full, list all, then pop a quarter of the entries back out
  task automatic test_fill_and_drain();
    set_pressure(7, 7);
    repeat (QDEPTH + 1)
      send_word(MODE_PUSH, ID_W'($urandom), {$urandom, $urandom}, 1'($urandom_range(1)));
    send_word(MODE_MARK, live_id(), '0, 1'b0);
    send_word(MODE_LIST, '0, '0, 1'b0);
    set_pressure(0, 73);
    repeat (QDEPTH / 4) begin
      if ($urandom_range(7) == 0)
        send_word(MODE_MARK, live_id(), '0, 1'b0);
      send_word(MODE_POP, '0, '0, 1'b0);
    end
    send_word(MODE_LIST, '0, '0, 1'b0);
  endtask

  // Random mix across every pressure setting; the ring has wrapped by now
  task automatic test_random_mix();
    set_pressure(0, 0);
    repeat (5) send_random(45, 20, 25);
    set_pressure(73, 0);
    repeat (5) send_random(35, 25, 25);
    set_pressure(0, 73);
    repeat (5) send_random(30, 30, 25);
    set_pressure(7, 7);
    repeat (5) send_random(35, 25, 25);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_field_extremes();
    test_mark_cases();
    test_fill_and_drain();
    test_random_mix();
    // let the tail of the replies come out with no stalls
    in_valid <= 1'b0;
    set_pressure(0, 0);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
